### rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types, constants and helpers of the line substring matcher.
// ----------------------------------------------------------------------------
package lsm_pkg;

    // default sizes handed to the top level parameters
    localparam int PATTERN_MAX_DEF  = 32;
    localparam int COUNTER_BITS_DEF = 32;

    // text constants
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // reported counter width
    localparam int COUNT_OUT_W = 32;

    // configuration port geometry
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;
    localparam int REG_LSB      = 3;
    localparam int REG_IDX_W    = 3;
    localparam int CFG_PAT_BYTES = 32;
    localparam int LENGTH_W     = 6;

    // register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LENGTH      = 3'd0,
        REG_PAT0        = 3'd1,
        REG_PAT1        = 3'd2,
        REG_PAT2        = 3'd3,
        REG_PAT3        = 3'd4,
        REG_IGNORE_CASE = 3'd5,
        REG_INVERT      = 3'd6
    } t_reg_idx;

    // settled configuration flags seen by the datapath
    typedef struct packed {
        logic ignore_case;
        logic empty_pattern;
        logic invert;
    } t_cfg_flags;

    // window control from the line logic
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

    // one result item
    typedef struct packed {
        logic                   line_valid;
        logic                   line_selected;
        logic                   line_contains;
        logic [COUNT_OUT_W-1:0] line_number;
        logic [COUNT_OUT_W-1:0] match_count;
        logic                   file_has_match;
        logic                   file_end;
    } t_result;

    // ascii upper to lower case folding
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

### rtl/lsm_if.sv
// ----------------------------------------------------------------------------
// lsm_if
// Valid/ready channels of the line substring matcher: text in, results out.
// ----------------------------------------------------------------------------
interface lsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       file_last;

    modport source (output valid, output text_byte, output byte_valid,
                    output file_last, input ready);
    modport sink   (input valid, input text_byte, input byte_valid,
                    input file_last, output ready);
endinterface

interface lsm_out_if;
    logic        valid;
    logic        ready;
    logic        line_valid;
    logic        line_selected;
    logic        line_contains;
    logic [31:0] line_number;
    logic [31:0] match_count;
    logic        file_has_match;
    logic        file_end;

    modport source (output valid, output line_valid, output line_selected,
                    output line_contains, output line_number, output match_count,
                    output file_has_match, output file_end, input ready);
    modport sink   (input valid, input line_valid, input line_selected,
                    input line_contains, input line_number, input match_count,
                    input file_has_match, input file_end, output ready);
endinterface

### rtl/lsm_cfg.sv
// ----------------------------------------------------------------------------
// lsm_cfg
// Configuration registers behind the APB port, plus a registered copy of the
// pattern aligned to the text window (last pattern byte at window slot 0).
// ----------------------------------------------------------------------------
module lsm_cfg #(
    parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lsm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lsm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [7:0]                      o_apat [PATTERN_MAX],
    output logic [PATTERN_MAX-1:0]          o_amask,
    output lsm_pkg::t_cfg_flags             o_flags
);

    localparam int STORE_BYTES = (PATTERN_MAX < lsm_pkg::CFG_PAT_BYTES) ?
                                 PATTERN_MAX : lsm_pkg::CFG_PAT_BYTES;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int WORDS = lsm_pkg::CFG_PAT_BYTES / 8;

    logic [lsm_pkg::LENGTH_W-1:0]   r_length;
    logic [7:0]                     r_pat [STORE_BYTES];
    logic                           r_ignore_case;
    logic                           r_invert;
    logic [7:0]                     r_apat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         r_amask;
    lsm_pkg::t_cfg_flags            r_flags;

    logic [7:0]                     w_pat [PATTERN_MAX];
    logic [lsm_pkg::APB_DATA_W-1:0] w_word [WORDS];
    logic [lsm_pkg::REG_IDX_W-1:0]  w_idx;
    logic                           w_we;
    logic [LEN_W-1:0]               w_eff;
    logic [LEN_W-1:0]               w_src [PATTERN_MAX];
    logic [7:0]                     n_apat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         n_amask;

    assign pready = 1'b1;
    assign w_idx  = paddr[lsm_pkg::REG_LSB +: lsm_pkg::REG_IDX_W];
    assign w_we   = psel && penable && pwrite;

    // scalar registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length      <= '0;
            r_ignore_case <= 1'b0;
            r_invert      <= 1'b0;
        end else if (w_we) begin
            case (lsm_pkg::t_reg_idx'(w_idx))
                lsm_pkg::REG_LENGTH:      r_length      <= pwdata[lsm_pkg::LENGTH_W-1:0];
                lsm_pkg::REG_IGNORE_CASE: r_ignore_case <= pwdata[0];
                lsm_pkg::REG_INVERT:      r_invert      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // pattern bytes, eight to a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < STORE_BYTES; p++) begin
                r_pat[p] <= 8'h00;
            end
        end else if (w_we) begin
            for (int p = 0; p < STORE_BYTES; p++) begin
                if (w_idx == lsm_pkg::REG_IDX_W'(int'(lsm_pkg::REG_PAT0) + p / 8)) begin
                    r_pat[p] <= pwdata[8 * (p % 8) +: 8];
                end
            end
        end
    end

    // full-depth pattern view, positions past the register file read zero
    // and readback words
    for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pat
        if (p < STORE_BYTES) begin : g_st
            assign w_pat[p] = r_pat[p];
        end else begin : g_zero
            assign w_pat[p] = 8'h00;
        end
    end

    for (genvar w = 0; w < WORDS; w++) begin : g_word
        for (genvar k = 0; k < 8; k++) begin : g_byte
            if (8 * w + k < STORE_BYTES) begin : g_st
                assign w_word[w][8 * k +: 8] = r_pat[8 * w + k];
            end else begin : g_zero
                assign w_word[w][8 * k +: 8] = 8'h00;
            end
        end
    end

    // register readback
    always_comb begin
        case (lsm_pkg::t_reg_idx'(w_idx))
            lsm_pkg::REG_LENGTH:      prdata = lsm_pkg::APB_DATA_W'(r_length);
            lsm_pkg::REG_PAT0:        prdata = w_word[0];
            lsm_pkg::REG_PAT1:        prdata = w_word[1];
            lsm_pkg::REG_PAT2:        prdata = w_word[2];
            lsm_pkg::REG_PAT3:        prdata = w_word[3];
            lsm_pkg::REG_IGNORE_CASE: prdata = lsm_pkg::APB_DATA_W'(r_ignore_case);
            lsm_pkg::REG_INVERT:      prdata = lsm_pkg::APB_DATA_W'(r_invert);
            default:                  prdata = '0;
        endcase
    end

    // effective length, clamped to the window depth
    always_comb begin
        if (32'(r_length) > 32'(PATTERN_MAX)) begin
            w_eff = LEN_W'(PATTERN_MAX);
        end else begin
            w_eff = LEN_W'(r_length);
        end
    end

    // align: slot j holds pattern byte eff-1-j, folded when case is ignored
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_align
        assign w_src[j]   = w_eff - LEN_W'(j) - LEN_W'(1);
        assign n_amask[j] = LEN_W'(j) < w_eff;
        assign n_apat[j]  = n_amask[j] ?
                            lsm_pkg::fold_byte(w_pat[w_src[j][IDX_W-1:0]], r_ignore_case) :
                            8'h00;
    end

    // settled copy used by the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amask <= '0;
            r_flags <= '0;
        end else begin
            r_amask               <= n_amask;
            r_flags.ignore_case   <= r_ignore_case;
            r_flags.empty_pattern <= (w_eff == '0);
            r_flags.invert        <= r_invert;
        end
    end

    always_ff @(posedge i_clk) begin
        r_apat <= n_apat;
    end

    assign o_apat  = r_apat;
    assign o_amask = r_amask;
    assign o_flags = r_flags;

endmodule

### rtl/lsm_window.sv
// ----------------------------------------------------------------------------
// lsm_window
// Shift window of the latest line bytes and the parallel compare of the
// window, with the incoming byte shifted in, against the aligned pattern.
// ----------------------------------------------------------------------------
module lsm_window #(
    parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsm_pkg::t_win_ctl      i_ctl,
    input  logic [7:0]             i_byte,
    input  logic [7:0]             i_apat [PATTERN_MAX],
    input  logic [PATTERN_MAX-1:0] i_amask,
    input  logic                   i_ignore_case,
    output logic                   o_hit
);

    logic [7:0]             r_win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_wvalid;
    logic [7:0]             n_win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] n_wvalid;
    logic [PATTERN_MAX-1:0] w_eq;

    // window after this byte: new byte in slot 0, the rest moved up one
    assign n_win[0]    = i_byte;
    assign n_wvalid[0] = 1'b1;
    for (genvar j = 1; j < PATTERN_MAX; j++) begin : g_shift
        assign n_win[j]    = r_win[j - 1];
        assign n_wvalid[j] = r_wvalid[j - 1];
    end

    // per-slot compare, slots past the pattern length always agree
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cmp
        assign w_eq[j] = !i_amask[j] ||
                         (n_wvalid[j] &&
                          lsm_pkg::fold_byte(n_win[j], i_ignore_case) == i_apat[j]);
    end

    assign o_hit = &w_eq;

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_ctl.clear) begin
            r_wvalid <= '0;
        end else if (i_ctl.shift) begin
            r_wvalid <= n_wvalid;
        end
    end

    // window bytes
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

endmodule

### rtl/line_substring_matcher.sv
// ----------------------------------------------------------------------------
// line_substring_matcher
// Fixed-pattern line filter: bytes stream in, one result per closed line
// or file end, with line number, match count and the selection flag.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------
//  i_in     | in  | valid/ready      | text_byte, byte_valid, file_last
//  o_out    | out | valid/ready      | line flags, line_number, match_count,
//           |     |                  | file_has_match, file_end
//  apb      | in  | psel/penable     | 64-bit registers at byte address 8*i
//
//  One item per cycle sustained while results are taken: input register, one
//  compare of the window against the aligned pattern and the line update,
//  then the result register. A result is valid once it is in that register.
//  Items that carry no newline and no file end never wait on the output side;
//  a held result only stalls items that have a result of their own.
//  Reset is synchronous and clears configuration, window and counters.
//  A register write reaches the compare through the settled copy in lsm_cfg.
// ----------------------------------------------------------------------------
module line_substring_matcher #(
    parameter int PATTERN_MAX  = lsm_pkg::PATTERN_MAX_DEF,
    parameter int COUNTER_BITS = lsm_pkg::COUNTER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lsm_in_if.sink                         i_in,
    lsm_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int OUT_W = lsm_pkg::COUNT_OUT_W;

    logic [7:0]              w_apat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]  w_amask;
    lsm_pkg::t_cfg_flags     w_flags;
    lsm_pkg::t_win_ctl       w_win_ctl;
    logic                    w_hit;

    // input register
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_bvalid;
    logic                    r_in_last;

    // line and file state
    logic                    r_line_hit;
    logic                    r_pending;
    logic [COUNTER_BITS-1:0] r_line_cnt;
    logic [COUNTER_BITS-1:0] r_hit_cnt;

    // result register
    logic                    r_out_valid;
    lsm_pkg::t_result        r_out;

    logic                    w_in_fire;
    logic                    w_out_free;
    logic                    w_step;
    logic                    w_newline;
    logic                    w_emit;
    logic                    w_close;
    logic                    w_hit_after;
    logic                    w_pending_after;
    logic                    w_contains;
    logic [COUNTER_BITS-1:0] w_line_inc;
    logic [COUNTER_BITS-1:0] w_hit_inc;
    logic [COUNTER_BITS-1:0] n_line_cnt;
    logic [COUNTER_BITS-1:0] n_hit_cnt;
    logic [OUT_W-1:0]        w_line_out;
    logic [OUT_W-1:0]        w_hit_out;
    lsm_pkg::t_result        n_out;

    lsm_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_apat  (w_apat),
        .o_amask (w_amask),
        .o_flags (w_flags)
    );

    lsm_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_win_ctl),
        .i_byte        (r_in_byte),
        .i_apat        (w_apat),
        .i_amask       (w_amask),
        .i_ignore_case (w_flags.ignore_case),
        .o_hit         (w_hit)
    );

    // flow control: items without a result pass even if the output is held
    assign w_newline  = r_in_bvalid && (r_in_byte == lsm_pkg::NEWLINE_BYTE);
    assign w_emit     = w_newline || r_in_last;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && (!w_emit || w_out_free);
    assign i_in.ready = !r_in_valid || w_step;
    assign w_in_fire  = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_byte   <= i_in.text_byte;
            r_in_bvalid <= i_in.byte_valid;
            r_in_last   <= i_in.file_last;
        end
    end

    // line update for the item in the input register
    assign w_hit_after     = r_line_hit || (r_in_bvalid && w_hit);
    assign w_pending_after = r_pending || r_in_bvalid;
    assign w_close         = w_newline || (r_in_last && w_pending_after);
    assign w_contains      = w_hit_after || w_flags.empty_pattern;

    assign w_win_ctl.shift = w_step && r_in_bvalid;
    assign w_win_ctl.clear = w_step && (w_close || r_in_last);

    // saturating counters
    assign w_line_inc = (r_line_cnt == '1) ? r_line_cnt : r_line_cnt + 1'b1;
    assign w_hit_inc  = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + 1'b1;
    assign n_line_cnt = w_close ? w_line_inc : r_line_cnt;
    assign n_hit_cnt  = (w_close && w_contains) ? w_hit_inc : r_hit_cnt;

    // counters reported at 32 bits, clamped
    assign w_line_out = (|(n_line_cnt >> OUT_W)) ? '1 : OUT_W'(n_line_cnt);
    assign w_hit_out  = (|(n_hit_cnt >> OUT_W)) ? '1 : OUT_W'(n_hit_cnt);

    // result assembly
    always_comb begin
        n_out.line_valid     = w_close;
        n_out.line_selected  = w_close && (w_contains ^ w_flags.invert);
        n_out.line_contains  = w_close && w_contains;
        n_out.line_number    = w_line_out;
        n_out.match_count    = w_hit_out;
        n_out.file_has_match = (n_hit_cnt != '0);
        n_out.file_end       = r_in_last;
    end

    // line and file state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_hit <= 1'b0;
            r_pending  <= 1'b0;
            r_line_cnt <= '0;
            r_hit_cnt  <= '0;
        end else if (w_step) begin
            if (w_close || r_in_last) begin
                r_line_hit <= 1'b0;
                r_pending  <= 1'b0;
            end else begin
                r_line_hit <= w_hit_after;
                r_pending  <= w_pending_after;
            end
            if (r_in_last) begin
                r_line_cnt <= '0;
                r_hit_cnt  <= '0;
            end else begin
                r_line_cnt <= n_line_cnt;
                r_hit_cnt  <= n_hit_cnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.line_valid     = r_out.line_valid;
    assign o_out.line_selected  = r_out.line_selected;
    assign o_out.line_contains  = r_out.line_contains;
    assign o_out.line_number    = r_out.line_number;
    assign o_out.match_count    = r_out.match_count;
    assign o_out.file_has_match = r_out.file_has_match;
    assign o_out.file_end       = r_out.file_end;

    // a closed line always carries a nonzero line number
    a_line_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.line_valid) |-> (r_out.line_number != '0))
        else $error("closed line reported with line number zero");

    // matching lines never outnumber lines
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.match_count <= r_out.line_number))
        else $error("match count above line number");

    // file match flag follows the match count
    a_file_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.file_has_match == (r_out.match_count != '0)))
        else $error("file match flag disagrees with match count");

    // a file end leaves the counters and line state clear
    a_file_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_last) |=>
            (r_line_cnt == '0 && r_hit_cnt == '0 && !r_pending && !r_line_hit))
        else $error("state not cleared after file end");

endmodule
